>>> hw/rtl/ordered_handle_list_macros.svh
// Assertion macros for the ordered handle list.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ORDERED_HANDLE_LIST_MACROS_SVH
`define ORDERED_HANDLE_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OHL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_handle_list: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OHL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_handle_list: next-cycle check failed");

`endif

>>> hw/rtl/ohl_pkg.sv
// Shared constants for the ordered handle list: default depth, payload width, codes.
// No dependencies.
package ohl_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int SEQ_W           = 64;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;

endpackage

>>> hw/rtl/ordered_handle_list.sv
// Top level of the ordered handle list: sequencer, link and sequence memories.
// Depends on ohl_pkg, ohl_slot_alloc and ordered_handle_list_macros.svh.
//
//  channel | direction | handshake          | beat fields
//  --------+-----------+--------------------+----------------------------------------------
//  in      | into      | in_valid/in_stall  | opcode, sequence_value, entry_handle
//  out     | out of    | out_valid/out_stall| status, assigned_handle, list_empty,
//          |           |                    | entry_count, oldest/newest handle+sequence
//
// Appends, rejected appends and rejected removes load the result register at the accepting
// edge. A remove of a live handle passes through ST_LINK and ST_FETCH: link memory read,
// relink plus sequence memory read of the new end entry, then result load.
// Reset clears the live bits, pointers and count at once; the memories need no clearing pass.
// A new beat is taken only when the sequencer is idle and the result register is empty or
// draining in the same cycle, so a stalled output holds the input off.

`include "ordered_handle_list_macros.svh"

module ordered_handle_list #(
    parameter int ENTRIES = ohl_pkg::ENTRIES_DEFAULT,
    parameter int IW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [ohl_pkg::SEQ_W-1:0] sequence_value,
    input  logic [IW-1:0]            entry_handle,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [IW-1:0]            assigned_handle,
    output logic                     list_empty,
    output logic [CW-1:0]            entry_count,
    output logic [IW-1:0]            oldest_handle,
    output logic [ohl_pkg::SEQ_W-1:0] oldest_sequence,
    output logic [IW-1:0]            newest_handle,
    output logic [ohl_pkg::SEQ_W-1:0] newest_sequence
);

    localparam int SW = ohl_pkg::SEQ_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LINK  = 3'b010,
        ST_FETCH = 3'b100
    } state_t;

    typedef struct packed {
        logic          set_en;
        logic          clr_en;
        logic [IW-1:0] idx;
    } alloc_ctl_t;

    typedef struct packed {
        logic          full;
        logic [IW-1:0] free_slot;
    } alloc_stat_t;

    // sequencer and list pointers
    state_t          state_reg, state_next;
    logic [IW-1:0]   oldest_reg, oldest_next;
    logic [IW-1:0]   newest_reg, newest_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [SW-1:0]   oldest_seq_reg, oldest_seq_next;
    logic [SW-1:0]   newest_seq_reg, newest_seq_next;
    logic [IW-1:0]   rm_handle_reg, rm_handle_next;
    logic            upd_old_reg, upd_old_next;
    logic            upd_new_reg, upd_new_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      status_reg;
    logic [IW-1:0]   assigned_reg;
    logic            empty_reg;
    logic [CW-1:0]   count_out_reg;
    logic [IW-1:0]   oldest_out_reg;
    logic [SW-1:0]   oldest_seq_out_reg;
    logic [IW-1:0]   newest_out_reg;
    logic [SW-1:0]   newest_seq_out_reg;

    logic            load_res;
    logic [1:0]      res_status;
    logic [IW-1:0]   res_assigned;

    // memories: prev/next links and sequence numbers, one read port each, registered read
    logic [SW-1:0]   seq_mem  [ENTRIES];
    logic [IW-1:0]   next_mem [ENTRIES];
    logic [IW-1:0]   prev_mem [ENTRIES];
    logic [SW-1:0]   seq_q;
    logic [IW-1:0]   next_q;
    logic [IW-1:0]   prev_q;

    logic            seq_we;
    logic [IW-1:0]   seq_waddr;
    logic [IW-1:0]   seq_raddr;
    logic            next_we;
    logic [IW-1:0]   next_waddr;
    logic [IW-1:0]   next_wdata;
    logic            prev_we;
    logic [IW-1:0]   prev_waddr;
    logic [IW-1:0]   prev_wdata;

    alloc_ctl_t      alloc_ctl;
    alloc_stat_t     alloc_stat;
    logic            handle_live;

    logic            in_acc;
    logic            is_oldest;
    logic            is_newest;

    ohl_slot_alloc #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (alloc_ctl),
        .query_idx  (entry_handle),
        .query_live (handle_live),
        .stat       (alloc_stat)
    );

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    // the removed entry is an end of the list exactly when it matches that pointer;
    // end links are not kept up to date, so they come from these compares
    assign is_oldest = (rm_handle_reg == oldest_reg);
    assign is_newest = (rm_handle_reg == newest_reg);

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        count_next      = count_reg;
        oldest_seq_next = oldest_seq_reg;
        newest_seq_next = newest_seq_reg;
        rm_handle_next  = rm_handle_reg;
        upd_old_next    = upd_old_reg;
        upd_new_next    = upd_new_reg;

        load_res        = 1'b0;
        res_status      = ohl_pkg::STATUS_DONE;
        res_assigned    = '0;

        seq_we          = 1'b0;
        seq_waddr       = alloc_stat.free_slot;
        seq_raddr       = is_oldest ? next_q : prev_q;
        next_we         = 1'b0;
        next_waddr      = newest_reg;
        next_wdata      = alloc_stat.free_slot;
        prev_we         = 1'b0;
        prev_waddr      = alloc_stat.free_slot;
        prev_wdata      = newest_reg;

        alloc_ctl       = '{set_en: 1'b0, clr_en: 1'b0, idx: alloc_stat.free_slot};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (opcode == ohl_pkg::OP_APPEND)
                    begin
                        load_res = 1'b1;
                        if (alloc_stat.full)
                        begin
                            res_status = ohl_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            res_assigned     = alloc_stat.free_slot;
                            alloc_ctl.set_en = 1'b1;
                            seq_we           = 1'b1;
                            prev_we          = 1'b1;
                            next_we          = (count_reg != '0);
                            newest_next      = alloc_stat.free_slot;
                            newest_seq_next  = sequence_value;
                            if (count_reg == '0)
                            begin
                                oldest_next     = alloc_stat.free_slot;
                                oldest_seq_next = sequence_value;
                            end
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (!handle_live)
                    begin
                        load_res   = 1'b1;
                        res_status = ohl_pkg::STATUS_NOT_LIVE;
                    end
                    else
                    begin
                        rm_handle_next = entry_handle;
                        state_next     = ST_LINK;
                    end
                end
            end

            ST_LINK:
            begin
                alloc_ctl.clr_en = 1'b1;
                alloc_ctl.idx    = rm_handle_reg;
                count_next       = count_reg - CW'(1);
                upd_old_next     = is_oldest && !is_newest;
                upd_new_next     = is_newest && !is_oldest;
                next_waddr       = prev_q;
                next_wdata       = next_q;
                prev_waddr       = next_q;
                prev_wdata       = prev_q;
                if (!is_oldest && !is_newest)
                begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
                if (is_oldest)
                begin
                    oldest_next = next_q;
                end
                if (is_newest)
                begin
                    newest_next = prev_q;
                end
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                if (upd_old_reg)
                begin
                    oldest_seq_next = seq_q;
                end
                if (upd_new_reg)
                begin
                    newest_seq_next = seq_q;
                end
                load_res   = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_res || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            upd_old_reg   <= 1'b0;
            upd_new_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            upd_old_reg   <= upd_old_next;
            upd_new_reg   <= upd_new_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        oldest_seq_reg <= oldest_seq_next;
        newest_seq_reg <= newest_seq_next;
        rm_handle_reg  <= rm_handle_next;
        if (load_res)
        begin
            status_reg         <= res_status;
            assigned_reg       <= res_assigned;
            empty_reg          <= (count_next == '0);
            count_out_reg      <= count_next;
            oldest_out_reg     <= (count_next == '0) ? '0 : oldest_next;
            oldest_seq_out_reg <= (count_next == '0) ? '0 : oldest_seq_next;
            newest_out_reg     <= (count_next == '0) ? '0 : newest_next;
            newest_seq_out_reg <= (count_next == '0) ? '0 : newest_seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_we)
        begin
            seq_mem[seq_waddr] <= sequence_value;
        end
        seq_q <= seq_mem[seq_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_q <= next_mem[entry_handle];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_q <= prev_mem[entry_handle];
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign assigned_handle = assigned_reg;
    assign list_empty      = empty_reg;
    assign entry_count     = count_out_reg;
    assign oldest_handle   = oldest_out_reg;
    assign oldest_sequence = oldest_seq_out_reg;
    assign newest_handle   = newest_out_reg;
    assign newest_sequence = newest_seq_out_reg;

    // a full table means every slot is counted
    `OHL_ASSERT_IMPL(a_full_count, alloc_stat.full, count_reg == CW'(ENTRIES))
    // a live remove always goes through the relink step
    `OHL_ASSERT_NEXT(a_remove_links,
        in_acc && (opcode == ohl_pkg::OP_REMOVE) && handle_live, state_reg == ST_LINK)
    // the result register is free while a remove is in flight
    `OHL_ASSERT_IMPL(a_link_out_free, state_reg == ST_LINK, !out_valid_reg)
    // the fetch step always presents a result
    `OHL_ASSERT_NEXT(a_fetch_result, state_reg == ST_FETCH, out_valid_reg)

endmodule

>>> hw/rtl/ohl_slot_alloc.sv
// Slot allocator: per-slot live bits, lowest-free search, live lookup by handle.
// Depends on nothing but its parameters; instantiated by ordered_handle_list.
module ohl_slot_alloc #(
    parameter int ENTRIES = 16,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IW+1:0]        ctl,        // {set_en, clr_en, set/clr index}
    input  logic [IW-1:0]        query_idx,
    output logic                 query_live,
    output logic [IW:0]          stat        // {full, free_slot}
);

    typedef struct packed {
        logic          set_en;
        logic          clr_en;
        logic [IW-1:0] idx;
    } alloc_ctl_t;

    typedef struct packed {
        logic          full;
        logic [IW-1:0] free_slot;
    } alloc_stat_t;

    alloc_ctl_t    ctl_s;
    alloc_stat_t   stat_s;
    logic [ENTRIES-1:0] live_reg;
    logic [ENTRIES-1:0] live_next;

    assign ctl_s = alloc_ctl_t'(ctl);
    assign stat  = stat_s;

    always_comb
    begin
        live_next = live_reg;
        if (ctl_s.set_en)
        begin
            live_next[ctl_s.idx] = 1'b1;
        end
        if (ctl_s.clr_en)
        begin
            live_next[ctl_s.idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    // lowest free slot wins
    always_comb
    begin
        stat_s.full      = 1'b1;
        stat_s.free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                stat_s.full      = 1'b0;
                stat_s.free_slot = IW'(i);
            end
        end
    end

    // handles at or beyond the depth are never live
    assign query_live = ({1'b0, query_idx} < (IW+1)'(ENTRIES)) && live_reg[query_idx];

endmodule
